// ===== hw/rtl/particle_slice_and_grid_deposit_macros.svh =====
// Assertion macros shared by the particle slice and grid deposit RTL.
`ifndef PARTICLE_SLICE_AND_GRID_DEPOSIT_MACROS_SVH
`define PARTICLE_SLICE_AND_GRID_DEPOSIT_MACROS_SVH

// Checked on every rising edge of clk_i, switched off while rst_ni is low.
`define PSGD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge of clk_i, including during reset.
`define PSGD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/psgd_pkg.sv =====
// Types and constants of the particle slice and grid deposit block.
`timescale 1ns / 1ps
`default_nettype none

package psgd_pkg;

  typedef enum logic [1:0] {
    FUNC_DEPOSIT   = 2'd0,
    FUNC_READ_SLC  = 2'd1,
    FUNC_READ_NODE = 2'd2,
    FUNC_CLEAR     = 2'd3
  } func_e;

  localparam logic [1:0] CFG_SLICE_COUNT   = 2'd0;
  localparam logic [1:0] CFG_HALF_RANGE    = 2'd1;
  localparam logic [1:0] CFG_INV_CELL_SIZE = 2'd2;

  localparam logic [10:0] SLICE_COUNT_RST   = 11'd1024;
  localparam logic [30:0] HALF_RANGE_RST    = 31'd16777216;
  localparam logic [31:0] INV_CELL_SIZE_RST = 32'd2097152;

  // Unity in Q1.16, the full weight of one axis.
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  typedef struct packed {
    func_e              func;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        energy_gamma;
    logic [31:0]        charge_weight;
    logic [9:0]         slice_index;
    logic [6:0]         node_i;
    logic [6:0]         node_j;
  } in_item_t;

  typedef struct packed {
    logic [47:0] slice_weight_sum;
    logic [63:0] slice_gamma_sum;
    logic [47:0] node_weight_sum;
    logic [63:0] total_weight;
    logic        landed_on_grid;
    logic        saturated;
  } out_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/particle_slice_and_grid_deposit.sv =====
// Particle slice and grid deposit: top level with slice and grid memories.
//
// The input channel (in_valid_i / in_ready_o / in_data_i) takes one beat per
// operation: deposit a particle, read a slice, read a grid node, or clear.
// Every beat, the clear included, yields exactly one result beat on the output
// channel (out_valid_o / out_ready_i / out_data_o). The block works on one
// operation at a time and takes a beat only while its sequencer is idle.
// A read, or a deposit that does not land on the grid, passes through S_CALC
// and S_FETCH to S_DONE, which loads the result register. A deposit that
// lands on the grid goes on through S_WXY and then reads, adds to and writes
// back the four grid nodes one after another through the single port pair of
// the grid memory, in S_GRD_RD and S_GRD_WB for each node, before S_DONE.
// A clear sweeps all memories one entry per cycle over max(MAX_SLICES,
// (GRID_CELLS+1)^2) entries (4225 with the defaults), then gives its result.
// The output register holds a finished result while the receiver stalls; the
// next beat is still taken and worked on, and it waits only for the register.
// After reset the same clearing pass runs before the first beat is taken;
// configuration writes are accepted at any time, including during the pass.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i.
`timescale 1ns / 1ps
`default_nettype none

`include "particle_slice_and_grid_deposit_macros.svh"

module particle_slice_and_grid_deposit #(
  parameter int GRID_CELLS = 64,
  parameter int MAX_SLICES = 1024
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire psgd_pkg::in_item_t   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output psgd_pkg::out_item_t       out_data_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_idx_i,
  input  wire logic [31:0]          cfg_data_i
);

  localparam int GRID_NODES = (GRID_CELLS + 1) * (GRID_CELLS + 1);
  localparam int SA         = $clog2(MAX_SLICES);
  localparam int GA         = $clog2(GRID_NODES);
  localparam int NB         = $clog2(GRID_CELLS + 1);
  localparam int CLR_DEPTH  = (MAX_SLICES > GRID_NODES) ? MAX_SLICES : GRID_NODES;
  localparam int CW         = $clog2(CLR_DEPTH);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CALC   = 8'b0000_0010,
    S_FETCH  = 8'b0000_0100,
    S_WXY    = 8'b0000_1000,
    S_GRD_RD = 8'b0001_0000,
    S_GRD_WB = 8'b0010_0000,
    S_DONE   = 8'b0100_0000,
    S_CLEAR  = 8'b1000_0000
  } state_e;

  // Configuration registers.
  logic [10:0] slice_count_q;
  logic [30:0] half_range_q;
  logic [31:0] inv_cell_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_count_q <= psgd_pkg::SLICE_COUNT_RST;
      half_range_q  <= psgd_pkg::HALF_RANGE_RST;
      inv_cell_q    <= psgd_pkg::INV_CELL_SIZE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        psgd_pkg::CFG_SLICE_COUNT:   slice_count_q <= cfg_data_i[10:0];
        psgd_pkg::CFG_HALF_RANGE:    half_range_q  <= cfg_data_i[30:0];
        psgd_pkg::CFG_INV_CELL_SIZE: inv_cell_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control state.
  state_e          state_q;
  logic [CW-1:0]   clr_cnt_q;
  logic            clr_reply_q;
  logic [1:0]      node_cnt_q;
  logic            out_valid_q;
  logic [63:0]     total_q;
  logic            sat_q;

  // Working registers of the current operation.
  psgd_pkg::in_item_t  item_q;
  psgd_pkg::out_item_t out_q;
  logic            slice_ok_q;
  logic            slice_rd_ok_q;
  logic            centre_q;
  logic            node_ok_q;
  logic            negx_q;
  logic            negy_q;
  logic [63:0]     px_q;
  logic [63:0]     py_q;
  logic [63:0]     gw_q;
  logic [NB-1:0]   ci_q;
  logic [NB-1:0]   cj_q;
  logic [16:0]     wx_q [2];
  logic [16:0]     wy_q [2];
  logic [32:0]     prod_q [4];
  logic [47:0]     share_q;
  logic [GA-1:0]   gaddr_q;
  logic [47:0]     res_sw_q;
  logic [63:0]     res_sg_q;
  logic [47:0]     res_nw_q;
  logic            res_landed_q;

  // Memories and their read data.
  logic [47:0]     slice_w_mem [MAX_SLICES];
  logic [63:0]     slice_g_mem [MAX_SLICES];
  logic [47:0]     grid_mem    [GRID_NODES];
  logic [47:0]     slw_rdata_q;
  logic [63:0]     slg_rdata_q;
  logic [47:0]     grid_rdata_q;

  logic            in_fire;
  logic            out_free;
  logic            clr_last;
  logic [16:0]     s_wide;
  logic [SA-1:0]   s_addr;
  logic signed [32:0] ux;
  logic signed [32:0] uy;
  logic [64:0]     tot_sum;
  logic [48:0]     slw_sum;
  logic [64:0]     slg_sum;
  logic [48:0]     grid_sum;
  logic [64:0]     share_full;
  logic [23:0]     cell_x;
  logic [23:0]     cell_y;
  logic            on_x;
  logic            on_y;
  logic            landed;
  logic [GA-1:0]   node_rd_addr;
  logic [GA-1:0]   loop_addr;
  logic [GA-1:0]   grid_raddr;
  logic [GA-1:0]   grid_waddr;
  logic [SA-1:0]   slice_waddr;
  logic            slice_we;
  logic            grid_we;
  logic [47:0]     slw_wdata;
  logic [63:0]     slg_wdata;
  logic [47:0]     grid_wdata;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign clr_last    = (clr_cnt_q == CW'(CLR_DEPTH - 1));

  assign s_wide = 17'(item_q.slice_index);
  assign s_addr = s_wide[SA-1:0];

  // Shift the positions onto the grid origin; a negative result is off grid.
  assign ux = $signed({item_q.pos_x[31], item_q.pos_x}) + $signed({2'b00, half_range_q});
  assign uy = $signed({item_q.pos_y[31], item_q.pos_y}) + $signed({2'b00, half_range_q});

  assign tot_sum  = {1'b0, total_q} + 65'(item_q.charge_weight);
  assign slw_sum  = {1'b0, slw_rdata_q} + 49'(item_q.charge_weight);
  assign slg_sum  = {1'b0, slg_rdata_q} + {1'b0, gw_q};
  assign grid_sum = {1'b0, grid_rdata_q} + {1'b0, share_q};

  // The cell is the integer part of the Q24.40 product, the fraction its top
  // sixteen fractional bits.
  assign cell_x = px_q[63:40];
  assign cell_y = py_q[63:40];
  assign on_x   = !negx_q && (32'(cell_x) < GRID_CELLS);
  assign on_y   = !negy_q && (32'(cell_y) < GRID_CELLS);
  assign landed = slice_ok_q && centre_q && on_x && on_y;

  assign node_rd_addr = GA'(32'(item_q.node_i) * (GRID_CELLS + 1) + 32'(item_q.node_j));
  assign loop_addr    = GA'((32'(ci_q) + 32'(node_cnt_q[1])) * (GRID_CELLS + 1)
                            + 32'(cj_q) + 32'(node_cnt_q[0]));
  assign grid_raddr   = (state_q == S_GRD_RD) ? loop_addr : node_rd_addr;
  assign share_full   = 65'(prod_q[node_cnt_q]) * 65'(item_q.charge_weight);

  // Memory write ports: the clearing pass writes zeros, otherwise the sums.
  always_comb begin
    slice_we    = 1'b0;
    grid_we     = 1'b0;
    slice_waddr = s_addr;
    grid_waddr  = gaddr_q;
    slw_wdata   = slw_sum[48] ? {48{1'b1}} : slw_sum[47:0];
    slg_wdata   = slg_sum[64] ? {64{1'b1}} : slg_sum[63:0];
    grid_wdata  = grid_sum[48] ? {48{1'b1}} : grid_sum[47:0];
    if (state_q == S_CLEAR) begin
      slice_we    = (32'(clr_cnt_q) < MAX_SLICES);
      grid_we     = (32'(clr_cnt_q) < GRID_NODES);
      slice_waddr = clr_cnt_q[SA-1:0];
      grid_waddr  = clr_cnt_q[GA-1:0];
      slw_wdata   = '0;
      slg_wdata   = '0;
      grid_wdata  = '0;
    end else if (state_q == S_FETCH) begin
      slice_we = slice_ok_q;
    end else if (state_q == S_GRD_WB) begin
      grid_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slice_we) begin
      slice_w_mem[slice_waddr] <= slw_wdata;
      slice_g_mem[slice_waddr] <= slg_wdata;
    end
    slw_rdata_q <= slice_w_mem[s_addr];
    slg_rdata_q <= slice_g_mem[s_addr];
  end

  always_ff @(posedge clk_i) begin
    if (grid_we) begin
      grid_mem[grid_waddr] <= grid_wdata;
    end
    grid_rdata_q <= grid_mem[grid_raddr];
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      clr_reply_q <= 1'b0;
      node_cnt_q  <= '0;
      out_valid_q <= 1'b0;
      total_q     <= '0;
      sat_q       <= 1'b0;
    end else begin
      // In S_DONE the valid flag is handled by the state itself.
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (in_data_i.func == psgd_pkg::FUNC_CLEAR) begin
              state_q     <= S_CLEAR;
              clr_cnt_q   <= '0;
              clr_reply_q <= 1'b1;
            end else begin
              state_q <= S_CALC;
            end
          end
        end
        S_CALC: begin
          if (item_q.func == psgd_pkg::FUNC_DEPOSIT) begin
            total_q <= tot_sum[64] ? {64{1'b1}} : tot_sum[63:0];
            if (tot_sum[64]) begin
              sat_q <= 1'b1;
            end
          end
          state_q <= S_FETCH;
        end
        S_FETCH: begin
          if (slice_ok_q && (slw_sum[48] || slg_sum[64])) begin
            sat_q <= 1'b1;
          end
          state_q <= landed ? S_WXY : S_DONE;
        end
        S_WXY: begin
          node_cnt_q <= '0;
          state_q    <= S_GRD_RD;
        end
        S_GRD_RD: begin
          state_q <= S_GRD_WB;
        end
        S_GRD_WB: begin
          if (grid_sum[48]) begin
            sat_q <= 1'b1;
          end
          node_cnt_q <= node_cnt_q + 2'd1;
          state_q    <= (node_cnt_q == 2'd3) ? S_DONE : S_GRD_RD;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_CLEAR: begin
          total_q   <= '0;
          sat_q     <= 1'b0;
          clr_cnt_q <= clr_cnt_q + CW'(1);
          if (clr_last) begin
            state_q <= clr_reply_q ? S_DONE : S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers of the operation in flight.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          item_q       <= in_data_i;
          res_sw_q     <= '0;
          res_sg_q     <= '0;
          res_nw_q     <= '0;
          res_landed_q <= 1'b0;
        end
      end
      S_CALC: begin
        slice_ok_q    <= (item_q.func == psgd_pkg::FUNC_DEPOSIT)
                         && (11'(item_q.slice_index) < slice_count_q)
                         && (32'(item_q.slice_index) < MAX_SLICES);
        slice_rd_ok_q <= (32'(item_q.slice_index) < MAX_SLICES);
        centre_q      <= (11'(item_q.slice_index) == (slice_count_q >> 1));
        node_ok_q     <= (32'(item_q.node_i) <= GRID_CELLS)
                         && (32'(item_q.node_j) <= GRID_CELLS);
        negx_q        <= ux[32];
        negy_q        <= uy[32];
        px_q          <= 64'(ux[31:0]) * 64'(inv_cell_q);
        py_q          <= 64'(uy[31:0]) * 64'(inv_cell_q);
        gw_q          <= 64'(item_q.energy_gamma) * 64'(item_q.charge_weight);
      end
      S_FETCH: begin
        ci_q     <= NB'(cell_x);
        cj_q     <= NB'(cell_y);
        wx_q[1]  <= 17'(px_q[39:24]);
        wx_q[0]  <= psgd_pkg::ONE_Q16 - 17'(px_q[39:24]);
        wy_q[1]  <= 17'(py_q[39:24]);
        wy_q[0]  <= psgd_pkg::ONE_Q16 - 17'(py_q[39:24]);
        res_landed_q <= landed;
        if (slice_ok_q) begin
          res_sw_q <= slw_wdata;
          res_sg_q <= slg_wdata;
        end else if (item_q.func == psgd_pkg::FUNC_READ_SLC && slice_rd_ok_q) begin
          res_sw_q <= slw_rdata_q;
          res_sg_q <= slg_rdata_q;
        end
        if (item_q.func == psgd_pkg::FUNC_READ_NODE && node_ok_q) begin
          res_nw_q <= grid_rdata_q;
        end
      end
      S_WXY: begin
        // Node order: low x low y, low x high y, high x low y, high x high y.
        prod_q[0] <= 33'(wx_q[0]) * 33'(wy_q[0]);
        prod_q[1] <= 33'(wx_q[0]) * 33'(wy_q[1]);
        prod_q[2] <= 33'(wx_q[1]) * 33'(wy_q[0]);
        prod_q[3] <= 33'(wx_q[1]) * 33'(wy_q[1]);
      end
      S_GRD_RD: begin
        share_q <= share_full[63:16];
        gaddr_q <= loop_addr;
      end
      S_DONE: begin
        if (out_free) begin
          out_q.slice_weight_sum <= res_sw_q;
          out_q.slice_gamma_sum  <= res_sg_q;
          out_q.node_weight_sum  <= res_nw_q;
          out_q.total_weight     <= total_q;
          out_q.landed_on_grid   <= res_landed_q;
          out_q.saturated        <= sat_q;
        end
      end
      default: ;
    endcase
  end

  `PSGD_ASSERT(a_no_accept_in_clear, state_q == S_CLEAR |-> !in_ready_o, "beat taken during clear")
  `PSGD_ASSERT(a_loop_starts_at_zero, state_q == S_WXY |=> node_cnt_q == 2'd0, "grid loop not at node zero")
  `PSGD_ASSERT(a_sat_falls_on_clear, $fell(sat_q) |-> $past(state_q == S_CLEAR), "saturation lost without clear")
  `PSGD_ASSERT_ALWAYS(a_grid_we_states, grid_we |-> (state_q == S_CLEAR || state_q == S_GRD_WB), "stray grid write")

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the particle slice and grid deposit block.
`timescale 1ns / 1ps
`default_nettype none

module testbench;

  localparam int GRID_CELLS = 64;
  localparam int MAX_SLICES = 1024;
  localparam int GRID_NODES = (GRID_CELLS + 1) * (GRID_CELLS + 1);
  localparam logic [63:0] MAX48 = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [63:0] MAX64 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  // Several clears, each a sweep over all memory entries, plus long stalls on both sides.
  localparam int CYCLE_LIMIT = 1500000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  psgd_pkg::in_item_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  psgd_pkg::out_item_t out_data_o;
  logic                cfg_we_i = 1'b0;
  logic [1:0]          cfg_idx_i = '0;
  logic [31:0]         cfg_data_i = '0;

  particle_slice_and_grid_deposit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Our own copy of the block's state and its configuration registers.
  logic [63:0] slice_weight_acc [MAX_SLICES];
  logic [63:0] slice_gamma_acc [MAX_SLICES];
  logic [63:0] node_charge [GRID_NODES];
  logic [63:0] charge_total;
  logic        clip_flag;
  logic [10:0] num_slices;
  logic [30:0] grid_half;
  logic [31:0] cells_per_unit;

  psgd_pkg::in_item_t  pending_beats[$];
  psgd_pkg::out_item_t awaited_results[$];

  bit     idle_on;
  bit     in_took, out_took;
  int     in_gap, rdy_wait;
  int     errors, cycles;
  int     n_deposit, n_landed, n_reads, n_clears, n_results;

  function automatic void wipe_stores();
    for (int k = 0; k < MAX_SLICES; k++) begin
      slice_weight_acc[k] = '0;
      slice_gamma_acc[k] = '0;
    end
    for (int k = 0; k < GRID_NODES; k++) node_charge[k] = '0;
    charge_total = '0;
    clip_flag = 1'b0;
  endfunction

  // Adds with clipping at the given maximum; clipping sets the sticky flag.
  function automatic logic [63:0] clip_add(logic [63:0] a, logic [63:0] b,
                                           logic [63:0] limit);
    logic [64:0] r;
    r = {1'b0, a} + {1'b0, b};
    if (r > {1'b0, limit}) begin
      clip_flag = 1'b1;
      return limit;
    end
    return r[63:0];
  endfunction

  // Maps a position to its cell and Q0.16 fraction; returns 0 when off grid.
  function automatic bit grid_cell(logic signed [31:0] pos, output int cell_no,
                                   output logic [16:0] frac);
    longint      u;
    logic [63:0] p;
    cell_no = 0;
    frac = '0;
    u = longint'(pos) + longint'({1'b0, grid_half});
    if (u < 0) return 0;
    p = 64'(u) * {32'b0, cells_per_unit};
    if ((p >> 40) >= 64'(GRID_CELLS)) return 0;
    cell_no = int'(p >> 40);
    frac = {1'b0, p[39:24]};
    return 1;
  endfunction

  // Works out the result of one accepted beat and updates the state copy.
  function automatic psgd_pkg::out_item_t deposit_predict(psgd_pkg::in_item_t it);
    psgd_pkg::out_item_t r;
    int          ci, cj, k;
    logic [16:0] fx, fy;
    logic [63:0] wx [2], wy [2];
    logic [63:0] w, share;
    bit          on_x, on_y;
    r = '0;
    w = {32'b0, it.charge_weight};
    case (it.func)
      psgd_pkg::FUNC_DEPOSIT: begin
        n_deposit++;
        charge_total = clip_add(charge_total, w, MAX64);
        if (it.slice_index < num_slices) begin
          slice_weight_acc[it.slice_index] =
            clip_add(slice_weight_acc[it.slice_index], w, MAX48);
          slice_gamma_acc[it.slice_index] = clip_add(slice_gamma_acc[it.slice_index],
            {32'b0, it.energy_gamma} * w, MAX64);
          r.slice_weight_sum = slice_weight_acc[it.slice_index][47:0];
          r.slice_gamma_sum = slice_gamma_acc[it.slice_index];
          on_x = grid_cell(it.pos_x, ci, fx);
          on_y = grid_cell(it.pos_y, cj, fy);
          if (11'(it.slice_index) == (num_slices >> 1) && on_x && on_y) begin
            wx[1] = 64'(fx);
            wx[0] = 64'(psgd_pkg::ONE_Q16 - fx);
            wy[1] = 64'(fy);
            wy[0] = 64'(psgd_pkg::ONE_Q16 - fy);
            for (int a = 0; a < 2; a++) begin
              for (int b = 0; b < 2; b++) begin
                share = ((wx[a] * wy[b]) * w) >> 16;
                k = (ci + a) * (GRID_CELLS + 1) + (cj + b);
                node_charge[k] = clip_add(node_charge[k], share, MAX48);
              end
            end
            r.landed_on_grid = 1'b1;
            n_landed++;
          end
        end
      end
      psgd_pkg::FUNC_READ_SLC: begin
        n_reads++;
        r.slice_weight_sum = slice_weight_acc[it.slice_index][47:0];
        r.slice_gamma_sum = slice_gamma_acc[it.slice_index];
      end
      psgd_pkg::FUNC_READ_NODE: begin
        n_reads++;
        if (it.node_i <= GRID_CELLS && it.node_j <= GRID_CELLS)
          r.node_weight_sum = node_charge[it.node_i * (GRID_CELLS + 1) + it.node_j][47:0];
      end
      default: begin
        n_clears++;
        wipe_stores();
      end
    endcase
    r.total_weight = charge_total;
    r.saturated = clip_flag;
    return r;
  endfunction

  // Mostly short gaps, now and then a long one, none at all in busy phases.
  function automatic int gap_len();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Random particle or command, shaped so that many land on the grid.
  function automatic psgd_pkg::in_item_t random_beat();
    psgd_pkg::in_item_t it;
    longint      span, u;
    int          r;
    it = '{func: psgd_pkg::FUNC_DEPOSIT, pos_x: $urandom, pos_y: $urandom,
           energy_gamma: $urandom, charge_weight: $urandom,
           slice_index: 10'($urandom), node_i: 7'($urandom), node_j: 7'($urandom)};
    r = $urandom_range(0, 199);
    if (r == 0) begin
      it.func = psgd_pkg::FUNC_CLEAR;
    end else if (r < 25) begin
      it.func = psgd_pkg::FUNC_READ_SLC;
      if ($urandom_range(0, 1)) it.slice_index = 10'(num_slices >> 1);
    end else if (r < 60) begin
      it.func = psgd_pkg::FUNC_READ_NODE;
      if ($urandom_range(0, 4) != 0) begin
        it.node_i = 7'($urandom_range(0, GRID_CELLS));
        it.node_j = 7'($urandom_range(0, GRID_CELLS));
      end
    end else begin
      r = $urandom_range(0, 9);
      if (r < 5) it.slice_index = 10'(num_slices >> 1);
      else if (r < 9) it.slice_index = 10'($urandom_range(0, num_slices - 1));
      if ($urandom_range(0, 4) != 0) it.charge_weight = $urandom_range(0, 32'h0010_0000);
      if ($urandom_range(0, 9) < 7) begin
        // Aim at the transverse window of the grid, slightly beyond its far edge.
        span = (cells_per_unit == 0) ? 64'h2_0000_0000
                                     : (64'(GRID_CELLS) << 40) / cells_per_unit;
        if (span > 64'h2_0000_0000) span = 64'h2_0000_0000;
        span = span + span / 8 + 1;
        u = (longint'({$urandom, $urandom}) & 64'h3_FFFF_FFFF) % span;
        it.pos_x = 32'(u - longint'({1'b0, grid_half}));
        u = (longint'({$urandom, $urandom}) & 64'h3_FFFF_FFFF) % span;
        it.pos_y = 32'(u - longint'({1'b0, grid_half}));
      end
    end
    return it;
  endfunction

  function automatic psgd_pkg::in_item_t particle(logic signed [31:0] x,
                                                  logic signed [31:0] y,
                                                  logic [31:0] g, logic [31:0] w,
                                                  logic [9:0] s);
    return '{func: psgd_pkg::FUNC_DEPOSIT, pos_x: x, pos_y: y, energy_gamma: g,
             charge_weight: w, slice_index: s, node_i: '0, node_j: '0};
  endfunction

  function automatic psgd_pkg::in_item_t command(psgd_pkg::func_e f, logic [9:0] s,
                                                 logic [6:0] ni, logic [6:0] nj);
    return '{func: f, pos_x: '0, pos_y: '0, energy_gamma: '0, charge_weight: '0,
             slice_index: s, node_i: ni, node_j: nj};
  endfunction

  // Register writes happen only while nothing is in flight, so the state copy
  // is updated at once.
  task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      psgd_pkg::CFG_SLICE_COUNT:   num_slices = value[10:0];
      psgd_pkg::CFG_HALF_RANGE:    grid_half = value[30:0];
      psgd_pkg::CFG_INV_CELL_SIZE: cells_per_unit = value;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_beats.size() != 0 || in_valid_i || awaited_results.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic random_phase(int n, bit idling);
    idle_on = idling;
    repeat (n) pending_beats.push_back(random_beat());
    drain();
  endtask

  // Input side: a new beat is presented at the falling edge once the last one
  // has been taken, after an optional gap.
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_took)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_beats.size() != 0) begin
        in_data_i <= pending_beats.pop_front();
        in_valid_i <= 1'b1;
        in_gap = gap_len();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output side: the receiver stalls for a random stretch after some beats.
  always @(negedge clk_i) begin
    if (rdy_wait > 0) begin
      rdy_wait--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (out_took) rdy_wait = gap_len();
    end
  end

  // Both handshakes are observed at the rising edge: accepted beats feed the
  // predictor, returned beats are checked against the oldest expectation.
  always @(posedge clk_i) begin
    psgd_pkg::out_item_t want;
    cycles++;
    in_took = rst_ni && in_valid_i && in_ready_o;
    out_took = rst_ni && out_valid_o && out_ready_i;
    if (in_took) awaited_results.push_back(deposit_predict(in_data_i));
    if (out_took) begin
      n_results++;
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: result beat with none expected: %p", $time, out_data_o);
      end else begin
        want = awaited_results.pop_front();
        if (want !== out_data_o) begin
          errors++;
          if (errors <= 20) begin
            if (want.slice_weight_sum !== out_data_o.slice_weight_sum)
              $display("%0t: slice_weight_sum expected %h got %h", $time,
                       want.slice_weight_sum, out_data_o.slice_weight_sum);
            if (want.slice_gamma_sum !== out_data_o.slice_gamma_sum)
              $display("%0t: slice_gamma_sum expected %h got %h", $time,
                       want.slice_gamma_sum, out_data_o.slice_gamma_sum);
            if (want.node_weight_sum !== out_data_o.node_weight_sum)
              $display("%0t: node_weight_sum expected %h got %h", $time,
                       want.node_weight_sum, out_data_o.node_weight_sum);
            if (want.total_weight !== out_data_o.total_weight)
              $display("%0t: total_weight expected %h got %h", $time,
                       want.total_weight, out_data_o.total_weight);
            if (want.landed_on_grid !== out_data_o.landed_on_grid)
              $display("%0t: landed_on_grid expected %b got %b", $time,
                       want.landed_on_grid, out_data_o.landed_on_grid);
            if (want.saturated !== out_data_o.saturated)
              $display("%0t: saturated expected %b got %b", $time,
                       want.saturated, out_data_o.saturated);
          end
        end
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    wipe_stores();
    num_slices = psgd_pkg::SLICE_COUNT_RST;
    grid_half = psgd_pkg::HALF_RANGE_RST;
    cells_per_unit = psgd_pkg::INV_CELL_SIZE_RST;
    idle_on = 1'b1;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed beats under the reset settings: the centre slice is 512 and the
    // grid spans plus and minus one unit with 32 cells per unit.
    pending_beats.push_back(particle(32'sd0, 32'sd0, 32'h0001_0000, 32'h0001_0000, 10'd512));
    pending_beats.push_back(particle(-32'sd16777216, -32'sd16777216, 32'h0002_8000,
                                     32'h0000_4000, 10'd512));  // low corner of the grid
    pending_beats.push_back(particle(32'sd16777215, 32'sd16777215, 32'h0001_0000,
                                     32'h0001_0000, 10'd512));  // just inside the far edge
    pending_beats.push_back(particle(32'sd16777216, 32'sd0, 32'h0001_0000,
                                     32'h0001_0000, 10'd512));  // far edge, off the grid
    pending_beats.push_back(particle(-32'sd16777217, 32'sd0, 32'h0001_0000,
                                     32'h0001_0000, 10'd512));  // below the origin
    pending_beats.push_back(particle(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                                     32'hFFFF_FFFF, 10'd512));
    pending_beats.push_back(particle(32'sd12345, -32'sd54321, 32'hFFFF_FFFF,
                                     32'hFFFF_FFFF, 10'd0));
    pending_beats.push_back(particle(32'sd0, 32'sd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                     10'd0));   // gamma sum clips
    pending_beats.push_back(particle(32'sd0, 32'sd0, 32'h1, 32'h0, 10'd1023));
    pending_beats.push_back(command(psgd_pkg::FUNC_READ_SLC, 10'd0, 7'd0, 7'd0));
    pending_beats.push_back(command(psgd_pkg::FUNC_READ_SLC, 10'd512, 7'd0, 7'd0));
    pending_beats.push_back(command(psgd_pkg::FUNC_READ_SLC, 10'd1023, 7'h7F, 7'h7F));
    pending_beats.push_back(command(psgd_pkg::FUNC_READ_NODE, 10'd0, 7'd32, 7'd32));
    pending_beats.push_back(command(psgd_pkg::FUNC_READ_NODE, 10'd0, 7'd0, 7'd0));
    pending_beats.push_back(command(psgd_pkg::FUNC_READ_NODE, 10'd0, 7'd64, 7'd64));
    pending_beats.push_back(command(psgd_pkg::FUNC_READ_NODE, 10'h3FF, 7'd65, 7'd3));
    pending_beats.push_back(command(psgd_pkg::FUNC_READ_NODE, 10'd0, 7'd3, 7'h7F));
    pending_beats.push_back(command(psgd_pkg::FUNC_CLEAR, 10'h3FF, 7'h7F, 7'h7F));
    pending_beats.push_back(command(psgd_pkg::FUNC_READ_SLC, 10'd0, 7'd0, 7'd0));
    drain();
    random_phase(200, 1'b1);

    // A single slice: slice 0 is the centre; the coarsest grid, starting at the origin.
    cfg_write(psgd_pkg::CFG_SLICE_COUNT, 32'd1);
    cfg_write(psgd_pkg::CFG_HALF_RANGE, 32'd0);
    cfg_write(psgd_pkg::CFG_INV_CELL_SIZE, 32'd1);
    pending_beats.push_back(particle(32'sd0, 32'sd0, 32'h0001_0000, 32'h0001_0000, 10'd1));
    random_phase(180, 1'b0);

    // Widest origin and the densest grid; writes to the unlisted index are ignored.
    cfg_write(psgd_pkg::CFG_SLICE_COUNT, 32'd3);
    cfg_write(psgd_pkg::CFG_HALF_RANGE, 32'hFFFF_FFFF);
    cfg_write(psgd_pkg::CFG_INV_CELL_SIZE, 32'hFFFF_FFFF);
    cfg_write(CFG_UNUSED, 32'h1234_5678);
    random_phase(200, 1'b1);

    // With no cell scaling every centre-slice particle past the origin falls on one node.
    cfg_write(psgd_pkg::CFG_SLICE_COUNT, 32'd1024);
    cfg_write(psgd_pkg::CFG_HALF_RANGE, 32'd16777216);
    cfg_write(psgd_pkg::CFG_INV_CELL_SIZE, 32'd0);
    random_phase(180, 1'b1);

    cfg_write(psgd_pkg::CFG_SLICE_COUNT, 32'd16);
    cfg_write(psgd_pkg::CFG_HALF_RANGE, 32'h1000_0000);
    cfg_write(psgd_pkg::CFG_INV_CELL_SIZE, 32'h0004_0000);
    random_phase(220, 1'b0);

    cfg_write(psgd_pkg::CFG_SLICE_COUNT, 32'd1023);
    cfg_write(psgd_pkg::CFG_HALF_RANGE, 32'h0080_0000);
    cfg_write(psgd_pkg::CFG_INV_CELL_SIZE, 32'h0080_0000);
    random_phase(220, 1'b1);

    repeat (50) @(posedge clk_i);
    $display("Covered %0d deposits (%0d spread onto the grid), %0d reads and %0d clears",
             n_deposit, n_landed, n_reads, n_clears);
    $display("over six register settings; %0d result beats compared, %0d mismatched.",
             n_results, errors);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
